// ===== rtl/siov_pkg.sv =====
// ----------------------------------------------------------------------------
// siov_pkg
// Shared types and constants for the sorted interval overlap sweep.
// ----------------------------------------------------------------------------
package siov_pkg;

   localparam int MAX_REGIONS_DEFAULT = 4096;

   localparam int CMD_W   = 2;
   localparam int INDEX_W = 12;
   localparam int POS_W   = 31;
   localparam int COUNT_W = 13;
   localparam int LEN_W   = 16;
   localparam int SUM_W   = POS_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
   } region_type;

   localparam int REGION_W = $bits(region_type);

endpackage

// ===== rtl/sorted_interval_overlap_sweep.sv =====
// ----------------------------------------------------------------------------
// sorted_interval_overlap_sweep
// Region table of one chromosome with a forward sweep for alignment overlap.
//
// Input words (req_) carry one of three commands: load a region into a table
// slot, begin a chromosome (sets the region count and rewinds the sweep), or
// query an alignment. Every word gives exactly one result word (rsp_); only a
// query can give overlap = 1.
// The region table sits in one RAM with a registered read port; all sweep
// and scan steps go through that port, reading in ST_ADV and ST_SCAN.
// Load, begin and unused words give their result one cycle after accept; a
// begin word then holds the input one more cycle while entry 0 is read. A
// query first advances the pointer while the alignment start lies beyond
// the tracked end, then scans from it until a hit, a region starting after
// the alignment end, or the table end.
// A new word is accepted once the previous one is done and the result
// register is free or being taken, so a stalled receiver holds one result
// and the next word waits behind it.
// Reset clears the region count, sweep pointer and tracked end; the table
// itself is not cleared and holds nothing meaningful until loaded.
// ----------------------------------------------------------------------------
module sorted_interval_overlap_sweep #(
   parameter int MAX_REGIONS = siov_pkg::MAX_REGIONS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [siov_pkg::CMD_W-1:0]    req_cmd,
   input  logic [siov_pkg::INDEX_W-1:0]  req_region_index,
   input  logic [siov_pkg::POS_W-1:0]    req_region_start,
   input  logic [siov_pkg::POS_W-1:0]    req_region_end,
   input  logic [siov_pkg::COUNT_W-1:0]  req_region_count,
   input  logic [siov_pkg::POS_W-1:0]    req_align_pos,
   input  logic [siov_pkg::LEN_W-1:0]    req_aln_len,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_overlap
);

   import siov_pkg::*;

   localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int PW = $clog2(MAX_REGIONS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BEGIN_WAIT,
      ST_ADV,
      ST_ADV_WAIT,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_RESP
   } state_type;

   state_type        state_ff;
   logic [PW-1:0]    count_ff;
   logic [PW-1:0]    ptr_ff;
   logic [PW-1:0]    scan_ff;
   logic [POS_W-1:0] tracked_end_ff;
   logic [POS_W-1:0] align_pos_ff;
   logic [SUM_W-1:0] aln_end_ff;
   logic             hit_ff;
   logic             rsp_valid_ff;
   logic             rsp_overlap_ff;

   logic             req_fire;
   logic             rsp_free;
   logic             rsp_set;
   logic [PW-1:0]    count_in;
   logic             index_ok;
   logic [PW-1:0]    ptr_in;
   logic             adv_go;
   logic             scan_go;
   logic             hit_now;
   logic             stop_now;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   region_type       ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   region_type       ram_rd_data;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_valid && req_ready;

   // load, begin and unused words answer right away, a query from ST_RESP
   assign rsp_set = (req_fire && (req_cmd != CMD_QUERY)) ||
                    ((state_ff == ST_RESP) && rsp_free);

   // count saturates at the table depth
   assign count_in = ({{(32-COUNT_W){1'b0}}, req_region_count} > 32'(MAX_REGIONS)) ?
                     PW'(MAX_REGIONS) : PW'(req_region_count);
   assign index_ok = {{(32-INDEX_W){1'b0}}, req_region_index} < 32'(MAX_REGIONS);

   assign ptr_in   = ptr_ff + PW'(1);
   assign adv_go   = (align_pos_ff > tracked_end_ff) && (ptr_ff < count_ff);
   assign scan_go  = scan_ff < count_ff;
   assign hit_now  = (aln_end_ff > {1'b0, ram_rd_data.start_pos}) &&
                     (align_pos_ff < ram_rd_data.end_pos);
   assign stop_now = {1'b0, ram_rd_data.start_pos} > aln_end_ff;

   assign ram_wr_en   = req_fire && (req_cmd == CMD_LOAD) && index_ok;
   assign ram_wr_addr = AW'(req_region_index);
   assign ram_wr_data = '{start_pos: req_region_start, end_pos: req_region_end};

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ram_rd_en = req_fire && (req_cmd == CMD_BEGIN) && (count_in != '0);
         end
         ST_ADV: begin
            ram_rd_en   = adv_go && (ptr_in < count_ff);
            ram_rd_addr = ptr_in[AW-1:0];
         end
         ST_SCAN: begin
            ram_rd_en   = scan_go;
            ram_rd_addr = scan_ff[AW-1:0];
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   siov_ram #(
      .WIDTH (REGION_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         ptr_ff         <= '0;
         tracked_end_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  align_pos_ff <= req_align_pos;
                  aln_end_ff   <= {1'b0, req_align_pos} +
                                  {{(SUM_W-LEN_W){1'b0}}, req_aln_len};
                  if (req_cmd == CMD_QUERY) begin
                     state_ff <= ST_ADV;
                  end else begin
                     rsp_overlap_ff <= 1'b0;
                     if (req_cmd == CMD_BEGIN) begin
                        count_ff <= count_in;
                        if (count_in != '0) begin
                           ptr_ff   <= '0;
                           state_ff <= ST_BEGIN_WAIT;
                        end
                     end
                  end
               end
            end
            ST_BEGIN_WAIT: begin
               tracked_end_ff <= ram_rd_data.end_pos;
               state_ff       <= ST_IDLE;
            end
            ST_ADV: begin
               if (adv_go) begin
                  ptr_ff <= ptr_in;
                  if (ptr_in < count_ff) begin
                     state_ff <= ST_ADV_WAIT;
                  end else begin
                     scan_ff  <= ptr_in;
                     state_ff <= ST_SCAN;
                  end
               end else begin
                  scan_ff  <= ptr_ff;
                  state_ff <= ST_SCAN;
               end
            end
            ST_ADV_WAIT: begin
               tracked_end_ff <= ram_rd_data.end_pos;
               state_ff       <= ST_ADV;
            end
            ST_SCAN: begin
               if (scan_go) begin
                  state_ff <= ST_SCAN_WAIT;
               end else begin
                  hit_ff   <= 1'b0;
                  state_ff <= ST_RESP;
               end
            end
            ST_SCAN_WAIT: begin
               if (hit_now) begin
                  hit_ff   <= 1'b1;
                  state_ff <= ST_RESP;
               end else if (stop_now) begin
                  hit_ff   <= 1'b0;
                  state_ff <= ST_RESP;
               end else begin
                  scan_ff  <= scan_ff + PW'(1);
                  state_ff <= ST_SCAN;
               end
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_overlap_ff <= hit_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

endmodule

// ===== rtl/siov_ram.sv =====
// ----------------------------------------------------------------------------
// siov_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module siov_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
